/* hdl/msim_pkg.sv */
package msim_pkg;

  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned SCORE_W        = FRAC_BITS + 1;
  localparam int unsigned TOTAL_W        = 8;
  localparam int unsigned BIN_W          = 5;
  localparam int unsigned DEF_SKETCH_LEN = 128;
  localparam int unsigned STEP_W         = $clog2(SCORE_W);

  localparam logic [BIN_W-1:0]   EMPTY_CODE = '1;
  localparam logic [SCORE_W-1:0] SCORE_ONE  = SCORE_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DONE
  } msim_state_e;

  typedef struct packed {
    logic count;
    logic start;
    logic div_step;
    logic load_out;
  } msim_cmd_t;

  typedef struct packed {
    logic out_free;
  } msim_sts_t;

endpackage

/* hdl/minhash_sketch_similarity.sv */
// channel  | handshake              | payload
// in       | in_valid_i/in_ready_o   | bin_a_i, bin_b_i, last_bin_i
// out      | out_valid_o/out_ready_i | score_q16_o, match_total_o, compared_total_o, overrun_o
// cfg      | cfg_we_i                | cfg_wdata_i
//
// one bin pair per cycle while a sketch streams in
// after the last pair, input stalls while the restoring divider forms
// one quotient bit per cycle
// the result sits in an output register; a stalled output holds the block
// in its final state until the waiting result is taken
// reset clears the counters, the mode register and the output valid
module minhash_sketch_similarity #(
  parameter int unsigned SKETCH_LEN = msim_pkg::DEF_SKETCH_LEN
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [msim_pkg::BIN_W-1:0] bin_a_i,
  input  logic signed [msim_pkg::BIN_W-1:0] bin_b_i,
  input  logic                              last_bin_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [msim_pkg::SCORE_W-1:0]      score_q16_o,
  output logic [msim_pkg::TOTAL_W-1:0]      match_total_o,
  output logic [msim_pkg::TOTAL_W-1:0]      compared_total_o,
  output logic                              overrun_o
);
  import msim_pkg::*;

  msim_cmd_t cmd;
  msim_sts_t sts;

  msim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_bin_i (last_bin_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  msim_dpath #(
    .SKETCH_LEN (SKETCH_LEN)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .bin_a_i          (bin_a_i),
    .bin_b_i          (bin_b_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .score_q16_o      (score_q16_o),
    .match_total_o    (match_total_o),
    .compared_total_o (compared_total_o),
    .overrun_o        (overrun_o)
  );

endmodule

/* hdl/msim_ctrl.sv */
module msim_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_bin_i,
  input  msim_pkg::msim_sts_t sts_i,
  output msim_pkg::msim_cmd_t cmd_o,
  output logic               in_ready_o
);
  import msim_pkg::*;

  msim_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == STEP_W'(SCORE_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_RUN: begin
        step_d = '0;
        if (in_valid_i && last_bin_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_RUN: begin
        in_ready_o  = 1'b1;
        cmd_o.count = in_valid_i;
        cmd_o.start = in_valid_i && last_bin_i;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/msim_dpath.sv */
module msim_dpath #(
  parameter int unsigned SKETCH_LEN = msim_pkg::DEF_SKETCH_LEN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msim_pkg::msim_cmd_t           cmd_i,
  output msim_pkg::msim_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic signed [msim_pkg::BIN_W-1:0] bin_a_i,
  input  logic signed [msim_pkg::BIN_W-1:0] bin_b_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [msim_pkg::SCORE_W-1:0]  score_q16_o,
  output logic [msim_pkg::TOTAL_W-1:0]  match_total_o,
  output logic [msim_pkg::TOTAL_W-1:0]  compared_total_o,
  output logic                          overrun_o
);
  import msim_pkg::*;

  localparam int unsigned CNT_W = $clog2(SKETCH_LEN + 1);

  logic             dist_q;
  logic [CNT_W-1:0] match_q, match_d;
  logic [CNT_W-1:0] empty_q, empty_d;
  logic [CNT_W-1:0] bins_q, bins_d;
  logic             ovf_q, ovf_d;

  logic             a_empty, b_empty, in_range, is_match, is_empty;
  logic [CNT_W-1:0] match_nx, empty_nx, bins_nx, den_nx;
  logic             ovf_nx;

  logic [CNT_W:0]   rem_q;
  logic [CNT_W-1:0] den_q;
  logic [SCORE_W-1:0] quot_q;
  logic             ovf_div_q;
  logic             qbit;
  logic [CNT_W:0]   rem_sub;

  logic [SCORE_W-1:0] sim, score;
  logic [CNT_W+TOTAL_W-1:0] den_ext;

  logic [CNT_W-1:0] match_div_q;
  logic [CNT_W+TOTAL_W-1:0] match_tot_ext;

  logic               out_valid_q;
  logic [SCORE_W-1:0] score_q;
  logic [TOTAL_W-1:0] match_out_q, cmp_out_q;
  logic               ovf_out_q;

  assign a_empty  = ($unsigned(bin_a_i) == EMPTY_CODE);
  assign b_empty  = ($unsigned(bin_b_i) == EMPTY_CODE);
  assign in_range = (bins_q < CNT_W'(SKETCH_LEN));
  assign is_match = !a_empty && !b_empty && (bin_a_i == bin_b_i);
  assign is_empty = a_empty && b_empty;

  assign match_nx = match_q + CNT_W'(in_range && is_match);
  assign empty_nx = empty_q + CNT_W'(in_range && is_empty);
  assign bins_nx  = bins_q + CNT_W'(in_range);
  assign ovf_nx   = ovf_q || !in_range;
  assign den_nx   = bins_nx - empty_nx;

  always_comb begin
    match_d = match_q;
    empty_d = empty_q;
    bins_d  = bins_q;
    ovf_d   = ovf_q;
    if (cmd_i.start) begin
      match_d = '0;
      empty_d = '0;
      bins_d  = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.count) begin
      match_d = match_nx;
      empty_d = empty_nx;
      bins_d  = bins_nx;
      ovf_d   = ovf_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q      <= 1'b0;
      match_q     <= '0;
      empty_q     <= '0;
      bins_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
      match_q <= match_d;
      empty_q <= empty_d;
      bins_q  <= bins_d;
      ovf_q   <= ovf_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per step
  assign qbit    = (rem_q >= {1'b0, den_q});
  assign rem_sub = rem_q - (qbit ? {1'b0, den_q} : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q     <= {1'b0, match_nx};
      den_q     <= den_nx;
      quot_q    <= '0;
      ovf_div_q <= ovf_nx;
    end else if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[CNT_W-1:0], 1'b0};
      quot_q <= {quot_q[SCORE_W-2:0], qbit};
    end
  end

  assign sim   = (den_q == '0) ? '0 : quot_q;
  assign score = dist_q ? (SCORE_ONE - sim) : sim;

  assign den_ext   = {{TOTAL_W{1'b0}}, den_q};

  // after the last step the remainder holds no count, so the match total is kept separately
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      match_div_q <= match_nx;
    end
  end

  assign match_tot_ext = {{TOTAL_W{1'b0}}, match_div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      score_q     <= score;
      match_out_q <= match_tot_ext[TOTAL_W-1:0];
      cmp_out_q   <= den_ext[TOTAL_W-1:0];
      ovf_out_q   <= ovf_div_q;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign score_q16_o      = score_q;
  assign match_total_o    = match_out_q;
  assign compared_total_o = cmp_out_q;
  assign overrun_o        = ovf_out_q;

endmodule

/* hdl/msim_checker.sv */
module msim_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              last_bin_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [msim_pkg::SCORE_W-1:0]      score_q16_o,
  input logic [msim_pkg::TOTAL_W-1:0]      match_total_o,
  input logic [msim_pkg::TOTAL_W-1:0]      compared_total_o,
  input logic                              overrun_o
);
  import msim_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(score_q16_o)
      && $stable(match_total_o) && $stable(compared_total_o) && $stable(overrun_o))
    else $error("result changed while stalled");

  // score never exceeds one
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_q16_o <= SCORE_ONE)
    else $error("score above one");

  // input closes after the last bin transfer
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_bin_i |=> !in_ready_o)
    else $error("input open during division");

  // a new result only appears while input is closed
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a finished division");

endmodule

bind minhash_sketch_similarity msim_checker u_checker (.*);

/* tb/tb_minhash_sketch_similarity.sv */
module tb_minhash_sketch_similarity;
  timeunit 1ns;
  timeprecision 1ps;

  import msim_pkg::*;

  localparam int unsigned DIV_LATENCY = SCORE_W + 4;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TOTAL_W-1:0] match_cnt;
    logic [TOTAL_W-1:0] compared;
    logic               overrun;
  } sketch_score_t;

  typedef enum int unsigned {
    KIND_MIXED,
    KIND_EMPTY,
    KIND_MATCH
  } sketch_kind_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic                      cfg_wdata_i = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [BIN_W-1:0]   bin_a_i     = '0;
  logic signed [BIN_W-1:0]   bin_b_i     = '0;
  logic                      last_bin_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [SCORE_W-1:0]        score_q16_o;
  logic [TOTAL_W-1:0]        match_total_o;
  logic [TOTAL_W-1:0]        compared_total_o;
  logic                      overrun_o;

  // predictor state
  int unsigned   matches_seen  = 0;
  int unsigned   empties_seen  = 0;
  int unsigned   bins_seen     = 0;
  logic          overrun_seen  = 1'b0;
  logic          distance_mode = 1'b0;
  sketch_score_t pending_scores[$];

  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          idle_en     = 1'b1;
  bit          valid_held  = 1'b0;

  minhash_sketch_similarity i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .bin_a_i          (bin_a_i),
    .bin_b_i          (bin_b_i),
    .last_bin_i       (last_bin_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .score_q16_o      (score_q16_o),
    .match_total_o    (match_total_o),
    .compared_total_o (compared_total_o),
    .overrun_o        (overrun_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts while idle_en is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic accumulate_bin_pair(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                                     input logic last);
    sketch_score_t     res;
    longint unsigned   denom;
    longint unsigned   sim;
    longint unsigned   one_q;
    if (bins_seen < DEF_SKETCH_LEN) begin
      if (a != EMPTY_CODE && b != EMPTY_CODE && a == b) matches_seen++;
      if (a == EMPTY_CODE && b == EMPTY_CODE) empties_seen++;
      bins_seen++;
    end else begin
      overrun_seen = 1'b1;
    end
    if (last) begin
      one_q = 64'd1 << FRAC_BITS;
      denom = bins_seen - empties_seen;
      sim   = 0;
      if (denom != 0) sim = (64'(matches_seen) << FRAC_BITS) / denom;
      res.score     = distance_mode ? SCORE_W'(one_q - sim) : SCORE_W'(sim);
      res.match_cnt = TOTAL_W'(matches_seen);
      res.compared  = TOTAL_W'(denom);
      res.overrun   = overrun_seen;
      pending_scores.insert(pending_scores.size(), res);
      matches_seen = 0;
      empties_seen = 0;
      bins_seen    = 0;
      overrun_seen = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic compare_score();
    sketch_score_t exp_s;
    if (pending_scores.size() == 0) begin
      $display("%0t unexpected result: score %0d matches %0d compared %0d overrun %0d",
               $time, score_q16_o, match_total_o, compared_total_o, overrun_o);
      errors++;
    end else begin
      exp_s = pending_scores.pop_front();
      check_field("score_q16", exp_s.score, score_q16_o);
      check_field("match_total", exp_s.match_cnt, match_total_o);
      check_field("compared_total", exp_s.compared, compared_total_o);
      check_field("overrun", exp_s.overrun, overrun_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) compare_score();
      if (in_valid_i && in_ready_o) accumulate_bin_pair(bin_a_i, bin_b_i, last_bin_i);
      if (cfg_we_i) distance_mode = cfg_wdata_i;
    end
  end

  task automatic send_pair(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                           input logic last);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    valid_held = 1'b1;
    bin_a_i    <= a;
    bin_b_i    <= b;
    last_bin_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_for_results();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    // let the monitor record the last transfer first
    @(posedge clk_i);
    while (pending_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    wait_for_results();
    // the divider is idle once every result is taken; this wait is only margin
    repeat (DIV_LATENCY) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [BIN_W-1:0] random_bin();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return EMPTY_CODE;
    if (r == 2) return BIN_W'($urandom_range(0, 31));
    return BIN_W'($urandom_range(0, 15));
  endfunction

  task automatic send_sketch(input int unsigned len, input sketch_kind_e kind);
    logic [BIN_W-1:0] a;
    logic [BIN_W-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        KIND_EMPTY: begin
          a = EMPTY_CODE;
          b = EMPTY_CODE;
        end
        KIND_MATCH: begin
          a = BIN_W'($urandom_range(0, 15));
          b = a;
        end
        default: begin
          a = random_bin();
          b = ($urandom_range(0, 1) == 1) ? a : random_bin();
        end
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic test_directed_scores();
    idle_en = 1'b1;
    // zero denominator, then a full match
    send_pair(EMPTY_CODE, EMPTY_CODE, 1'b1);
    send_pair(5'sd15, 5'sd15, 1'b1);
    // mixed sketch with odd codes compared as raw bits
    send_pair(5'sd0, 5'sd0, 1'b0);
    send_pair(5'sd15, 5'sd15, 1'b0);
    send_pair(EMPTY_CODE, 5'sd3, 1'b0);
    send_pair(5'sd3, EMPTY_CODE, 1'b0);
    send_pair(EMPTY_CODE, EMPTY_CODE, 1'b0);
    send_pair(5'b10000, 5'b10000, 1'b0);
    send_pair(5'b11110, 5'b11110, 1'b0);
    send_pair(5'sd5, 5'sd7, 1'b0);
    send_pair(5'b10000, 5'sd15, 1'b1);
    set_mode(1'b1);
    send_pair(EMPTY_CODE, EMPTY_CODE, 1'b1);
    send_pair(5'sd7, 5'sd7, 1'b1);
    send_pair(5'sd1, 5'sd2, 1'b0);
    send_pair(5'sd2, 5'sd2, 1'b1);
    set_mode(1'b0);
  endtask

  task automatic test_sketch_length_limit();
    idle_en = 1'b1;
    send_sketch(DEF_SKETCH_LEN, KIND_MATCH);
    send_sketch(DEF_SKETCH_LEN + 3, KIND_MIXED);
    set_mode(1'b1);
    send_sketch(DEF_SKETCH_LEN + 1, KIND_MATCH);
    send_sketch(DEF_SKETCH_LEN, KIND_EMPTY);
    set_mode(1'b0);
  endtask

  task automatic test_random_sketches(input int unsigned item_goal);
    int unsigned  goal;
    int unsigned  len;
    int unsigned  r;
    sketch_kind_e kind;
    goal    = items_sent + item_goal;
    idle_en = 1'b1;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 12);
      else if (r < 96) len = $urandom_range(13, DEF_SKETCH_LEN);
      else len = $urandom_range(DEF_SKETCH_LEN + 1, DEF_SKETCH_LEN + 8);
      r = $urandom_range(0, 19);
      kind = (r == 0) ? KIND_EMPTY : ((r == 1) ? KIND_MATCH : KIND_MIXED);
      send_sketch(len, kind);
      r = $urandom_range(0, 29);
      if (r == 0) set_mode(1'($urandom_range(0, 1)));
      else if (r < 3) wait_for_results();
    end
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_mode(1'b1);
    for (int unsigned k = 0; k < 12; k++) send_sketch($urandom_range(1, 16), KIND_MIXED);
    set_mode(1'b0);
    for (int unsigned k = 0; k < 6; k++) send_sketch($urandom_range(1, 16), KIND_MIXED);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_scores();
    test_sketch_length_limit();
    test_random_sketches(1200);
    test_steady_stream();
    wait_for_results();
    repeat (DIV_LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/msim_pkg.sv
hdl/msim_ctrl.sv
hdl/msim_dpath.sv
hdl/minhash_sketch_similarity.sv
hdl/msim_checker.sv
tb/tb_minhash_sketch_similarity.sv
